// ===== src/iprt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the IPv4 route table.
package iprt_pkg;

   localparam int ADDR_W          = 32;
   localparam int PREFIX_W        = 6;
   localparam int IFACE_W         = 4;
   localparam int IFACE_CNT_W     = 5;
   localparam int UP_MASK_W       = 16;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int ROUTE_SLOTS_DEF = 16;
   localparam int IFACE_COUNT_DEF = 16;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // register index taken from paddr above the byte offset
   localparam logic CSR_IFACE_UP = 1'b0;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [ADDR_W-1:0]   dest;
      logic [ADDR_W-1:0]   gateway;
      logic [ADDR_W-1:0]   netmask;
      logic [IFACE_W-1:0]  iface;
      logic                via;
      logic [PREFIX_W-1:0] prefix;
   } req_type;

   typedef struct packed {
      logic                valid;
      logic [ADDR_W-1:0]   dest;
      logic [PREFIX_W-1:0] prefix;
      logic [ADDR_W-1:0]   gateway;
      logic [IFACE_W-1:0]  iface;
      logic                via;
   } entry_type;

   // token that walks the row of cells, one cell per cycle
   typedef struct packed {
      logic                active;
      logic                found;
      logic                placed;
      logic [PREFIX_W-1:0] prefix;
      logic [ADDR_W-1:0]   gateway;
      logic [IFACE_W-1:0]  iface;
      logic                via;
   } carry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   hit_gateway;
      logic [IFACE_W-1:0]  hit_iface;
      logic                hit_via_gateway;
      logic [ADDR_W-1:0]   next_hop;
      logic [PREFIX_W-1:0] hit_prefix;
   } result_type;

   // 32 minus trailing zeros, zero for an all-zero mask
   function automatic logic [PREFIX_W-1:0] prefix_of(input logic [ADDR_W-1:0] mask);
      logic [ADDR_W-1:0]   x;
      logic [PREFIX_W-1:0] tz;
      x  = mask;
      tz = '0;
      if (x[15:0] == 16'h0) begin
         tz = tz + 6'd16;
         x  = x >> 16;
      end
      if (x[7:0] == 8'h0) begin
         tz = tz + 6'd8;
         x  = x >> 8;
      end
      if (x[3:0] == 4'h0) begin
         tz = tz + 6'd4;
         x  = x >> 4;
      end
      if (x[1:0] == 2'h0) begin
         tz = tz + 6'd2;
         x  = x >> 2;
      end
      if (x[0] == 1'b0) begin
         tz = tz + 6'd1;
      end
      if (mask == '0) begin
         return '0;
      end
      return PREFIX_W'(ADDR_W) - tz;
   endfunction

   // contiguous mask of a prefix length
   function automatic logic [ADDR_W-1:0] mask_of(input logic [PREFIX_W-1:0] prefix);
      if (prefix >= PREFIX_W'(ADDR_W)) begin
         return '1;
      end
      return ~({ADDR_W{1'b1}} >> prefix);
   endfunction

endpackage

// ===== src/iprt_cell.sv =====
`timescale 1ns / 1ps
// One route slot with its compare logic and the token register to the next slot.
module iprt_cell
   import iprt_pkg::*;
#(
   parameter int IFACE_COUNT = IFACE_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req,
   input  logic [UP_MASK_W-1:0] up_mask,
   input  carry_type            carry_in,
   output carry_type            carry_out,
   input  entry_type            next_entry,
   input  logic                 next_take,
   output entry_type            entry_out,
   output logic                 take_out
);

   entry_type entry_ff, entry_in;
   carry_type carry_ff, carry_in_nx;
   logic      iface_up;
   logic      look_hit;
   logic      del_hit;
   logic      add_here;
   logic [ADDR_W-1:0] look_mask;

   always_comb begin
      iface_up  = ({1'b0, entry_ff.iface} < IFACE_CNT_W'(IFACE_COUNT))
                  && up_mask[entry_ff.iface];
      look_mask = mask_of(entry_ff.prefix);
      look_hit  = entry_ff.valid && iface_up
                  && ((entry_ff.dest & look_mask) == (req.dest & look_mask));
      del_hit   = entry_ff.valid && (entry_ff.prefix == req.prefix)
                  && ((entry_ff.dest & req.netmask) == (req.dest & req.netmask));
      add_here  = carry_in.active && (req.op == OP_ADD)
                  && !entry_ff.valid && !carry_in.placed;
   end

   // hand this slot down when a delete hit lies at or before the slot below
   assign take_out = carry_in.active && (req.op == OP_DELETE) && carry_in.found;

   always_comb begin
      entry_in = entry_ff;
      if (next_take) begin
         entry_in = next_entry;
      end else if (add_here) begin
         entry_in.valid   = 1'b1;
         entry_in.dest    = req.dest;
         entry_in.prefix  = req.prefix;
         entry_in.gateway = req.gateway;
         entry_in.iface   = req.iface;
         entry_in.via     = req.via;
      end
   end

   always_comb begin
      carry_in_nx = carry_in;
      case (req.op)
         OP_ADD: begin
            carry_in_nx.placed = carry_in.placed || !entry_ff.valid;
         end
         OP_DELETE: begin
            carry_in_nx.found = carry_in.found || del_hit;
         end
         OP_LOOKUP: begin
            if (look_hit && (!carry_in.found || (entry_ff.prefix > carry_in.prefix))) begin
               carry_in_nx.found   = 1'b1;
               carry_in_nx.prefix  = entry_ff.prefix;
               carry_in_nx.gateway = entry_ff.gateway;
               carry_in_nx.iface   = entry_ff.iface;
               carry_in_nx.via     = entry_ff.via;
            end
         end
         default: begin
            carry_in_nx = carry_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid  <= 1'b0;
         carry_ff.active <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         carry_ff <= carry_in_nx;
      end
   end

   assign carry_out = carry_ff;
   assign entry_out = entry_ff;

endmodule

// ===== src/ipv4_route_table_lpm.sv =====
`timescale 1ns / 1ps
// Top level of the IPv4 longest-prefix route table: request control, cell row, result and CSR.
//
// Bounded IPv4 route table built as a row of ROUTE_SLOTS cells, one route per cell, routes
// kept packed at the low cells in insertion order. Every request (add, delete, lookup) is
// served by a token that walks the row one cell per clock: each cell compares its own route
// against the held request and updates the token (free slot taken, first delete hit, best
// prefix so far). Delete closes the gap on the way: once the token has seen the hit, each
// later cell hands its route to the cell below, and the last cell empties at the end of the
// walk. From acceptance, a request's token passes every cell of the row and the result register is
// loaded before the next request can be accepted. Requests are taken one at a time; req_stall is
// high for the whole walk and while a finished result waits for a free output register. Lookup
// skips routes whose interface bit in iface_up_mask (CSR at byte address 0) is clear, or whose
// interface number is at or above IFACE_COUNT; ties on prefix length go to the earliest route.
// Results other than a lookup hit carry status only, every other field zero. Write the CSR only
// while no request is in flight.
module ipv4_route_table_lpm
   import iprt_pkg::*;
#(
   parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF,
   parameter int IFACE_COUNT = IFACE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [ADDR_W-1:0]     req_dest_addr,
   input  logic [ADDR_W-1:0]     req_gateway_addr,
   input  logic [ADDR_W-1:0]     req_netmask,
   input  logic [IFACE_W-1:0]    req_iface_id,
   input  logic                  req_via_gateway,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_hit_gateway,
   output logic [IFACE_W-1:0]    rsp_hit_iface,
   output logic                  rsp_hit_via_gateway,
   output logic [ADDR_W-1:0]     rsp_next_hop,
   output logic [PREFIX_W-1:0]   rsp_hit_prefix,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type state_ff, state_in;

   req_type    req_ff;
   logic       start_ff;
   logic [UP_MASK_W-1:0] iface_up_ff;

   result_type res;
   result_type hold_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   logic req_accept;
   logic out_free;
   logic load_fin;
   logic stash_fin;
   logic load_hold;

   carry_type carry_head;
   carry_type carry_w [0:ROUTE_SLOTS];
   entry_type entry_w [0:ROUTE_SLOTS];
   logic      take_w  [0:ROUTE_SLOTS];
   logic [ROUTE_SLOTS-1:0] slot_vld;
   logic [ROUTE_SLOTS:0]   token_vec;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_up_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == CSR_IFACE_UP)) begin
         iface_up_ff <= csr_pwdata[UP_MASK_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IFACE_UP) begin
         csr_prdata = {{(CSR_DATA_W-UP_MASK_W){1'b0}}, iface_up_ff};
      end
   end

   // ---------------------------------------------------------------- request control
   assign req_accept = req_valid && !req_stall;
   // the output register can take a result at this edge
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (carry_w[ROUTE_SLOTS].active) begin
               state_in = out_free ? S_IDLE : S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_fin  = 1'b0;
      stash_fin = 1'b0;
      load_hold = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_SWEEP: begin
            load_fin  = carry_w[ROUTE_SLOTS].active && out_free;
            stash_fin = carry_w[ROUTE_SLOTS].active && !out_free;
         end
         S_HOLD: begin
            load_hold = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_accept;
      end
   end

   // hold the request steady for the whole walk; prefix length worked out once here
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.op      <= req_opcode;
         req_ff.dest    <= req_dest_addr;
         req_ff.gateway <= req_gateway_addr;
         req_ff.netmask <= req_netmask;
         req_ff.iface   <= req_iface_id;
         req_ff.via     <= req_via_gateway;
         req_ff.prefix  <= prefix_of(req_netmask);
      end
   end

   // ---------------------------------------------------------------- row of cells
   // inject a fresh token into the first cell the cycle after acceptance
   always_comb begin
      carry_head        = '0;
      carry_head.active = start_ff;
   end

   assign carry_w[0] = carry_head;

   // past the last cell sits an empty slot; it moves in when a delete hit was seen
   assign entry_w[ROUTE_SLOTS] = '0;
   assign take_w[ROUTE_SLOTS]  = carry_w[ROUTE_SLOTS].active && (req_ff.op == OP_DELETE)
                                 && carry_w[ROUTE_SLOTS].found;

   for (genvar g = 0; g < ROUTE_SLOTS; g++) begin : g_cell
      iprt_cell #(
         .IFACE_COUNT (IFACE_COUNT)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .req        (req_ff),
         .up_mask    (iface_up_ff),
         .carry_in   (carry_w[g]),
         .carry_out  (carry_w[g+1]),
         .next_entry (entry_w[g+1]),
         .next_take  (take_w[g+1]),
         .entry_out  (entry_w[g]),
         .take_out   (take_w[g])
      );
      assign slot_vld[g] = entry_w[g].valid;
   end

   always_comb begin
      for (int k = 0; k <= ROUTE_SLOTS; k++) begin
         token_vec[k] = carry_w[k].active;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      res = '0;
      case (req_ff.op)
         OP_ADD: begin
            res.status = carry_w[ROUTE_SLOTS].placed ? STATUS_OK : STATUS_FULL;
         end
         OP_DELETE: begin
            res.status = carry_w[ROUTE_SLOTS].found ? STATUS_OK : STATUS_NOT_FOUND;
         end
         OP_LOOKUP: begin
            if (carry_w[ROUTE_SLOTS].found) begin
               res.status          = STATUS_OK;
               res.hit_gateway     = carry_w[ROUTE_SLOTS].gateway;
               res.hit_iface       = carry_w[ROUTE_SLOTS].iface;
               res.hit_via_gateway = carry_w[ROUTE_SLOTS].via;
               res.next_hop        = carry_w[ROUTE_SLOTS].via ? carry_w[ROUTE_SLOTS].gateway
                                                              : req_ff.dest;
               res.hit_prefix      = carry_w[ROUTE_SLOTS].prefix;
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            res.status = STATUS_OK;
         end
      endcase
   end

   // park a finished result while the output register is still taken
   always_ff @(posedge clock) begin
      if (stash_fin) begin
         hold_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fin) begin
         rsp_ff <= res;
      end else if (load_hold) begin
         rsp_ff <= hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_fin || load_hold) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_hit_gateway     = rsp_ff.hit_gateway;
   assign rsp_hit_iface       = rsp_ff.hit_iface;
   assign rsp_hit_via_gateway = rsp_ff.hit_via_gateway;
   assign rsp_next_hop        = rsp_ff.next_hop;
   assign rsp_hit_prefix      = rsp_ff.hit_prefix;

   // ---------------------------------------------------------------- assertions
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one request token in the cell row");

   a_token_in_sweep : assert property (@(posedge clock) disable iff (reset)
      (token_vec != '0) |-> (state_ff == S_SWEEP))
      else $error("request token in the row outside a walk");

   a_hold_needs_out : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("result parked with a free output register");

   a_packed_slots : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((slot_vld & (slot_vld + 1'b1)) == '0))
      else $error("routes not packed at the low slots");

endmodule
